@@ hdl/lav_pkg.sv @@
`default_nettype none
package lav_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CW = 32;
    // width of a vector entry that goes into normalization
    localparam int NV_W = FRAC_BITS + 35;
    localparam int POS_W = $clog2(NV_W);
    // the largest normalized magnitude of a nonzero vector lies in [2^29, 2^30)
    localparam int NM_W = 30;
    localparam int NM_TOP = NM_W - 1;
    localparam int SUM_W = 2 * NM_W + 2;
    localparam int ROOT_W = NM_W + 1;
    localparam int SQ_N = ROOT_W;
    localparam int QW = FRAC_BITS + 1;
    localparam int DV_W = FRAC_BITS + ROOT_W + 1;
    localparam int DV_N = QW;
    localparam int VEC_W = FRAC_BITS + 2;
    localparam int UW = FRAC_BITS + 5;
    localparam int PW = VEC_W + CW;
    localparam int PU_W = 2 * VEC_W;
    localparam int EU_W = PU_W + 1;
    localparam int PD_W = UW + CW;
    localparam int TW = PD_W + 2;
    localparam int TS_W = TW + 1 - FRAC_BITS;
    localparam int SB_W = 6 * CW + 1;
    localparam int SB_FLAG = 6 * CW;

    localparam logic [1:0] ROW_S = 2'd0;
    localparam logic [1:0] ROW_U = 2'd1;
    localparam logic [1:0] ROW_V = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic                      valid;
        logic                      zero;
        logic [2:0]                neg;
        logic [2:0][NM_W-1:0]      m;
        logic [SB_W-1:0]           sb;
    } t_nrm_ctl;

    typedef struct packed {
        logic                      degen;
        logic [2:0][3:0][CW-1:0]   ent;
    } t_mat;
endpackage
`default_nettype wire

@@ hdl/look_at_view_matrix.sv @@
`default_nettype none
// look-at view matrix
// input channel: i_valid / o_stall with eye, target and up in signed fixed point
// (FRAC_BITS fraction bits); an item is taken when i_valid is high and o_stall low.
// output channel: o_valid / i_stall; each item gives four row items, row 0 first,
// o_last_row marks row 3 and o_degenerate is the same on all four rows.
// the first row of an item shows after the item has passed both normalizers;
// the rest follow one a cycle unless stalled.
// each item needs four row items on the single output port; the pipeline
// behind it takes one item per cycle until it fills.
// the depth comes from two normalizers, each a one-bit-per-stage square root
// and a one-bit-per-stage three-lane divider.
// when the receiver stalls, the row stays on the ports and the whole pipeline
// freezes once a finished matrix is waiting, which raises o_stall.
// reset clears all valid bits; the block takes an item in the next cycle.
module look_at_view_matrix import lav_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_eye_x,
    input  logic signed [CW-1:0] i_eye_y,
    input  logic signed [CW-1:0] i_eye_z,
    input  logic signed [CW-1:0] i_target_x,
    input  logic signed [CW-1:0] i_target_y,
    input  logic signed [CW-1:0] i_target_z,
    input  logic signed [CW-1:0] i_up_x,
    input  logic signed [CW-1:0] i_up_y,
    input  logic signed [CW-1:0] i_up_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_row_index,
    output logic signed [CW-1:0] o_col0,
    output logic signed [CW-1:0] o_col1,
    output logic signed [CW-1:0] o_col2,
    output logic signed [CW-1:0] o_col3,
    output logic                 o_last_row,
    output logic                 o_degenerate
);
    logic                    en, take;
    logic signed [NV_W-1:0]  d [3];
    logic                    n1_v, n1_ok, n2_v, n2_ok;
    logic signed [VEC_W-1:0] n1_c [3];
    logic signed [VEC_W-1:0] n2_c [3];
    logic [SB_W-1:0]         n1_sb, n2_sb, c1_sb;
    logic signed [CW-1:0]    up1 [3];
    logic signed [CW-1:0]    eye2 [3];
    logic signed [VEC_W-1:0] v2 [3];
    logic signed [NV_W-1:0]  sx [3];

    logic                    r_c1_v, r_c1_ok;
    logic signed [PW-1:0]    r_c1_p [6];
    logic signed [CW-1:0]    r_c1_eye [3];
    logic signed [VEC_W-1:0] r_c1_vv [3];

    logic                    r_u1_v, r_u1_dg;
    logic signed [PU_W-1:0]  r_u1_p [6];
    logic signed [VEC_W-1:0] r_u1_s [3];
    logic signed [VEC_W-1:0] r_u1_vv [3];
    logic signed [CW-1:0]    r_u1_eye [3];

    logic signed [EU_W-1:0]  ux [3];
    logic                    r_u2_v, r_u2_dg;
    logic signed [UW-1:0]    r_u2_u [3];
    logic signed [VEC_W-1:0] r_u2_s [3];
    logic signed [VEC_W-1:0] r_u2_vv [3];
    logic signed [CW-1:0]    r_u2_eye [3];

    logic                    r_d1_v, r_d1_dg;
    logic signed [PD_W-1:0]  r_d1_p [3][3];
    logic signed [UW-1:0]    r_d1_u [3];
    logic signed [VEC_W-1:0] r_d1_s [3];
    logic signed [VEC_W-1:0] r_d1_vv [3];

    logic                    r_d2_v, r_d2_dg;
    logic signed [TW-1:0]    r_d2_t [3];
    logic signed [UW-1:0]    r_d2_u [3];
    logic signed [VEC_W-1:0] r_d2_s [3];
    logic signed [VEC_W-1:0] r_d2_vv [3];

    logic signed [TW:0]      tx [3];
    logic signed [TS_W-1:0]  ty [3];
    logic [CW-1:0]           tsat [3];
    logic                    r_d3_v;
    t_mat                    r_d3_mat;

    assign en = take || !r_d3_v;
    assign o_stall = !en;

    assign d[0] = NV_W'(i_target_x) - NV_W'(i_eye_x);
    assign d[1] = NV_W'(i_target_y) - NV_W'(i_eye_y);
    assign d[2] = NV_W'(i_target_z) - NV_W'(i_eye_z);

    lav_norm u_norm_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_c0    (d[0]),
        .i_c1    (d[1]),
        .i_c2    (d[2]),
        .i_sb    ({1'b0, i_eye_x, i_eye_y, i_eye_z, i_up_x, i_up_y, i_up_z}),
        .o_valid (n1_v),
        .o_ok    (n1_ok),
        .o_c0    (n1_c[0]),
        .o_c1    (n1_c[1]),
        .o_c2    (n1_c[2]),
        .o_sb    (n1_sb)
    );

    assign up1[0] = signed'(n1_sb[3*CW-1 -: CW]);
    assign up1[1] = signed'(n1_sb[2*CW-1 -: CW]);
    assign up1[2] = signed'(n1_sb[CW-1 -: CW]);

    // v x up products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
        end else if (en) begin
            r_c1_v <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_ok <= n1_ok;
            r_c1_p[0] <= n1_c[1] * up1[2];
            r_c1_p[1] <= n1_c[2] * up1[1];
            r_c1_p[2] <= n1_c[2] * up1[0];
            r_c1_p[3] <= n1_c[0] * up1[2];
            r_c1_p[4] <= n1_c[0] * up1[1];
            r_c1_p[5] <= n1_c[1] * up1[0];
            r_c1_eye[0] <= signed'(n1_sb[6*CW-1 -: CW]);
            r_c1_eye[1] <= signed'(n1_sb[5*CW-1 -: CW]);
            r_c1_eye[2] <= signed'(n1_sb[4*CW-1 -: CW]);
            for (int i = 0; i < 3; i++) r_c1_vv[i] <= n1_c[i];
        end
    end

    assign sx[0] = NV_W'(r_c1_p[0]) - NV_W'(r_c1_p[1]);
    assign sx[1] = NV_W'(r_c1_p[2]) - NV_W'(r_c1_p[3]);
    assign sx[2] = NV_W'(r_c1_p[4]) - NV_W'(r_c1_p[5]);
    assign c1_sb = {r_c1_ok, r_c1_eye[0], r_c1_eye[1], r_c1_eye[2],
                    CW'(r_c1_vv[0]), CW'(r_c1_vv[1]), CW'(r_c1_vv[2])};

    lav_norm u_norm_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c1_v),
        .i_c0    (sx[0]),
        .i_c1    (sx[1]),
        .i_c2    (sx[2]),
        .i_sb    (c1_sb),
        .o_valid (n2_v),
        .o_ok    (n2_ok),
        .o_c0    (n2_c[0]),
        .o_c1    (n2_c[1]),
        .o_c2    (n2_c[2]),
        .o_sb    (n2_sb)
    );

    assign eye2[0] = signed'(n2_sb[6*CW-1 -: CW]);
    assign eye2[1] = signed'(n2_sb[5*CW-1 -: CW]);
    assign eye2[2] = signed'(n2_sb[4*CW-1 -: CW]);
    assign v2[0] = VEC_W'(signed'(n2_sb[3*CW-1 -: CW]));
    assign v2[1] = VEC_W'(signed'(n2_sb[2*CW-1 -: CW]));
    assign v2[2] = VEC_W'(signed'(n2_sb[CW-1 -: CW]));

    // u = s x v, then dot products with the eye
    always_comb begin
        ux[0] = EU_W'(r_u1_p[0]) - EU_W'(r_u1_p[1]) + EU_W'(1 << (FRAC_BITS - 1));
        ux[1] = EU_W'(r_u1_p[2]) - EU_W'(r_u1_p[3]) + EU_W'(1 << (FRAC_BITS - 1));
        ux[2] = EU_W'(r_u1_p[4]) - EU_W'(r_u1_p[5]) + EU_W'(1 << (FRAC_BITS - 1));
    end

    // row 2 is -v, so its translation is +v.eye
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r == 2) begin
                tx[r] = (TW+1)'(r_d2_t[r]) + (TW+1)'(1 << (FRAC_BITS - 1));
            end else begin
                tx[r] = -(TW+1)'(r_d2_t[r]) + (TW+1)'(1 << (FRAC_BITS - 1));
            end
            ty[r] = TS_W'(tx[r] >>> FRAC_BITS);
            if (ty[r] > TS_W'(2147483647)) begin
                tsat[r] = {1'b0, {(CW-1){1'b1}}};
            end else if (ty[r] < -TS_W'(64'sd2147483648)) begin
                tsat[r] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                tsat[r] = CW'(ty[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1_v <= 1'b0;
            r_u2_v <= 1'b0;
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_d3_v <= 1'b0;
        end else if (en) begin
            r_u1_v <= n2_v;
            r_u2_v <= r_u1_v;
            r_d1_v <= r_u2_v;
            r_d2_v <= r_d1_v;
            r_d3_v <= r_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u1_dg <= !(n2_ok && n2_sb[SB_FLAG]);
            r_u1_p[0] <= n2_c[1] * v2[2];
            r_u1_p[1] <= n2_c[2] * v2[1];
            r_u1_p[2] <= n2_c[2] * v2[0];
            r_u1_p[3] <= n2_c[0] * v2[2];
            r_u1_p[4] <= n2_c[0] * v2[1];
            r_u1_p[5] <= n2_c[1] * v2[0];
            r_u2_dg <= r_u1_dg;
            r_d1_dg <= r_u2_dg;
            r_d2_dg <= r_d1_dg;
            for (int i = 0; i < 3; i++) begin
                r_u1_s[i] <= n2_c[i];
                r_u1_vv[i] <= v2[i];
                r_u1_eye[i] <= eye2[i];
                r_u2_u[i] <= UW'(ux[i] >>> FRAC_BITS);
                r_u2_s[i] <= r_u1_s[i];
                r_u2_vv[i] <= r_u1_vv[i];
                r_u2_eye[i] <= r_u1_eye[i];
                r_d1_p[0][i] <= PD_W'(r_u2_s[i]) * PD_W'(r_u2_eye[i]);
                r_d1_p[1][i] <= PD_W'(r_u2_u[i]) * PD_W'(r_u2_eye[i]);
                r_d1_p[2][i] <= PD_W'(r_u2_vv[i]) * PD_W'(r_u2_eye[i]);
                r_d1_u[i] <= r_u2_u[i];
                r_d1_s[i] <= r_u2_s[i];
                r_d1_vv[i] <= r_u2_vv[i];
                r_d2_t[i] <= TW'(r_d1_p[i][0]) + TW'(r_d1_p[i][1]) + TW'(r_d1_p[i][2]);
                r_d2_u[i] <= r_d1_u[i];
                r_d2_s[i] <= r_d1_s[i];
                r_d2_vv[i] <= r_d1_vv[i];
                r_d3_mat.ent[0][i] <= CW'(r_d2_s[i]);
                r_d3_mat.ent[1][i] <= CW'(r_d2_u[i]);
                r_d3_mat.ent[2][i] <= CW'(-CW'(r_d2_vv[i]));
                r_d3_mat.ent[i][3] <= tsat[i];
            end
            r_d3_mat.degen <= r_d2_dg;
        end
    end

    lav_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_d3_v),
        .i_mat        (r_d3_mat),
        .o_take       (take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_last_row   (o_last_row),
        .o_degenerate (o_degenerate)
    );
endmodule
`default_nettype wire

@@ hdl/lav_norm.sv @@
`default_nettype none
module lav_norm import lav_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [NV_W-1:0]  i_c0,
    input  logic signed [NV_W-1:0]  i_c1,
    input  logic signed [NV_W-1:0]  i_c2,
    input  logic [SB_W-1:0]         i_sb,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic signed [VEC_W-1:0] o_c0,
    output logic signed [VEC_W-1:0] o_c1,
    output logic signed [VEC_W-1:0] o_c2,
    output logic [SB_W-1:0]         o_sb
);
    logic                   r0_v, r1_v, r2_v;
    logic signed [NV_W-1:0] r0_c [3];
    logic [SB_W-1:0]        r0_sb, r1_sb, r2_sb;
    logic [NV_W-1:0]        mag [3];
    logic [NV_W-1:0]        r1_m [3];
    logic [NV_W-1:0]        r2_m [3];
    logic [2:0]             r1_neg, r2_neg;
    logic [NV_W-1:0]        r1_or;
    logic [POS_W-1:0]       pos;
    logic [POS_W-1:0]       r2_pos;
    logic                   r2_zero;
    logic [NV_W-1:0]        sh [3];
    t_nrm_ctl               r3_ctl, r4_ctl;
    logic [2*NM_W-1:0]      r4_sq [3];
    t_nrm_ctl               r_sq_ctl [SQ_N+1];
    logic [SUM_W-1:0]       r_sq_rem [SQ_N+1];
    logic [ROOT_W-1:0]      r_sq_root [SQ_N+1];
    t_nrm_ctl               r_dv_ctl [DV_N+1];
    logic [ROOT_W-1:0]      r_dv_d [DV_N+1];
    logic [DV_W-1:0]        r_dv_rem [DV_N+1][3];
    logic [QW-1:0]          r_dv_q [DV_N+1][3];
    logic                   r_o_v, r_o_ok;
    logic signed [VEC_W-1:0] r_o_c [3];
    logic [SB_W-1:0]        r_o_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r_sq_ctl[0] <= '0;
            r_dv_ctl[0] <= '0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_ctl.valid <= r2_v;
            r3_ctl.zero <= r2_zero;
            r3_ctl.neg <= r2_neg;
            for (int i = 0; i < 3; i++) r3_ctl.m[i] <= sh[i][NM_W-1:0];
            r3_ctl.sb <= r2_sb;
            r4_ctl <= r3_ctl;
            r_sq_ctl[0] <= r4_ctl;
            r_dv_ctl[0] <= r_sq_ctl[SQ_N];
            r_o_v <= r_dv_ctl[DV_N].valid;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = r0_c[i][NV_W-1] ? NV_W'(-r0_c[i]) : NV_W'(r0_c[i]);
        end
    end

    // msb of the or of the magnitudes is the msb of the largest one
    always_comb begin
        pos = '0;
        for (int b = 0; b < NV_W; b++) begin
            if (r1_or[b]) pos = POS_W'(b);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r2_pos >= POS_W'(NM_TOP)) begin
                sh[i] = r2_m[i] >> (r2_pos - POS_W'(NM_TOP));
            end else begin
                sh[i] = r2_m[i] << (POS_W'(NM_TOP) - r2_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_c[0] <= i_c0;
            r0_c[1] <= i_c1;
            r0_c[2] <= i_c2;
            r0_sb <= i_sb;
            for (int i = 0; i < 3; i++) begin
                r1_m[i] <= mag[i];
                r1_neg[i] <= r0_c[i][NV_W-1];
                r2_m[i] <= r1_m[i];
                r4_sq[i] <= (2*NM_W)'(r3_ctl.m[i]) * (2*NM_W)'(r3_ctl.m[i]);
            end
            r1_or <= mag[0] | mag[1] | mag[2];
            r1_sb <= r0_sb;
            r2_neg <= r1_neg;
            r2_pos <= pos;
            r2_zero <= ~|r1_or;
            r2_sb <= r1_sb;
            r_sq_rem[0] <= SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
            r_sq_root[0] <= '0;
            r_dv_d[0] <= r_sq_root[SQ_N];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= (DV_W'(r_sq_ctl[SQ_N].m[i]) << FRAC_BITS)
                    + DV_W'(r_sq_root[SQ_N] >> 1);
                r_dv_q[0][i] <= '0;
            end
        end
    end

    // one root bit per stage
    genvar j;
    for (j = 1; j <= SQ_N; j++) begin : g_sq
        localparam int K = SQ_N - j;
        logic [63:0] t;
        assign t = (64'(r_sq_root[j-1]) << (K + 1)) | (64'd1 << (2 * K));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_ctl[j] <= '0;
            end else if (i_en) begin
                r_sq_ctl[j] <= r_sq_ctl[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (64'(r_sq_rem[j-1]) >= t) begin
                    r_sq_rem[j] <= r_sq_rem[j-1] - SUM_W'(t);
                    r_sq_root[j] <= r_sq_root[j-1] | (ROOT_W'(1) << K);
                end else begin
                    r_sq_rem[j] <= r_sq_rem[j-1];
                    r_sq_root[j] <= r_sq_root[j-1];
                end
            end
        end
    end

    // one quotient bit per stage, three lanes
    for (j = 1; j <= DV_N; j++) begin : g_dv
        localparam int K = DV_N - j;
        logic [DV_W-1:0] dk;
        assign dk = DV_W'(r_dv_d[j-1]) << K;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[j] <= '0;
            end else if (i_en) begin
                r_dv_ctl[j] <= r_dv_ctl[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_d[j] <= r_dv_d[j-1];
                for (int i = 0; i < 3; i++) begin
                    if (r_dv_rem[j-1][i] >= dk) begin
                        r_dv_rem[j][i] <= r_dv_rem[j-1][i] - dk;
                        r_dv_q[j][i] <= r_dv_q[j-1][i] | (QW'(1) << K);
                    end else begin
                        r_dv_rem[j][i] <= r_dv_rem[j-1][i];
                        r_dv_q[j][i] <= r_dv_q[j-1][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_ok <= !r_dv_ctl[DV_N].zero;
            r_o_sb <= r_dv_ctl[DV_N].sb;
            for (int i = 0; i < 3; i++) begin
                if (r_dv_ctl[DV_N].zero) begin
                    r_o_c[i] <= '0;
                end else if (r_dv_ctl[DV_N].neg[i]) begin
                    r_o_c[i] <= -signed'(VEC_W'(r_dv_q[DV_N][i]));
                end else begin
                    r_o_c[i] <= signed'(VEC_W'(r_dv_q[DV_N][i]));
                end
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_ok = r_o_ok;
    assign o_c0 = r_o_c[0];
    assign o_c1 = r_o_c[1];
    assign o_c2 = r_o_c[2];
    assign o_sb = r_o_sb;
endmodule
`default_nettype wire

@@ hdl/lav_ser.sv @@
`default_nettype none
module lav_ser import lav_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_mat                 i_mat,
    output logic                 o_take,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_row_index,
    output logic signed [CW-1:0] o_col0,
    output logic signed [CW-1:0] o_col1,
    output logic signed [CW-1:0] o_col2,
    output logic signed [CW-1:0] o_col3,
    output logic                 o_last_row,
    output logic                 o_degenerate
);
    logic       r_v;
    logic [1:0] r_row;
    t_mat       r_mat;
    logic       take;

    assign take = !r_v || (!i_stall && r_row == ROW_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            r_row <= ROW_S;
        end else if (take) begin
            r_v <= i_valid;
            r_row <= ROW_S;
        end else if (!i_stall) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) r_mat <= i_mat;
    end

    always_comb begin
        case (r_row)
            ROW_S, ROW_U, ROW_V: begin
                o_col0 = r_mat.ent[r_row][0];
                o_col1 = r_mat.ent[r_row][1];
                o_col2 = r_mat.ent[r_row][2];
                o_col3 = r_mat.ent[r_row][3];
            end
            default: begin
                o_col0 = '0;
                o_col1 = '0;
                o_col2 = '0;
                o_col3 = CW'(1 << FRAC_BITS);
            end
        endcase
    end

    assign o_take = take;
    assign o_valid = r_v;
    assign o_row_index = r_row;
    assign o_last_row = (r_row == ROW_LAST);
    assign o_degenerate = r_mat.degen;

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !i_stall && r_row != ROW_LAST |=> r_v && r_row == $past(r_row) + 2'd1)
        else $error("row counter skipped");
    a_mat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !take |=> $stable(r_mat))
        else $error("matrix changed mid item");
    a_new_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_valid |=> r_v && r_row == ROW_S)
        else $error("new item not started at row 0");
endmodule
`default_nettype wire

@@ tb/sv/tb_look_at_view_matrix.sv @@
`default_nettype none
module tb_look_at_view_matrix;
    import lav_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * FRAC_BITS + 87;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]           row;
        logic signed [31:0]   c0;
        logic signed [31:0]   c1;
        logic signed [31:0]   c2;
        logic signed [31:0]   c3;
        logic                 last;
        logic                 degen;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [CW-1:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic signed [CW-1:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic signed [CW-1:0] i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_row_index;
    logic signed [CW-1:0] o_col0, o_col1, o_col2, o_col3;
    logic o_last_row, o_degenerate;

    t_row rows_due[$];
    int   errors = 0;
    int   quiet_cycles = 0;
    bit   sender_gaps = 1'b1;
    bit   receiver_gaps = 1'b1;
    bit   hold_receiver = 1'b0;

    always #4 i_clk = ~i_clk;

    look_at_view_matrix i_dut (.*);

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_half_up(longint x);
        return (x + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // scale-free normalize; returns 0 and zeroes vector when it has no length
    function automatic bit unit_vector(ref longint v[3]);
        logic [63:0] m[3];
        logic [63:0] big, sum, len, q;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            v[0] = 0; v[1] = 0; v[2] = 0;
            return 1'b0;
        end
        while (big >= (64'd1 << 30)) begin
            big >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (big < (64'd1 << 29)) begin
            big <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    task automatic predict_view_rows(longint eye[3], longint tgt[3], longint up[3]);
        longint fwd[3], rgt[3], tup[3], ent[3], dot;
        bit ok_f, ok_r, degen;
        t_row r;
        for (int i = 0; i < 3; i++) fwd[i] = tgt[i] - eye[i];
        ok_f = unit_vector(fwd);
        rgt[0] = fwd[1] * up[2] - fwd[2] * up[1];
        rgt[1] = fwd[2] * up[0] - fwd[0] * up[2];
        rgt[2] = fwd[0] * up[1] - fwd[1] * up[0];
        ok_r = unit_vector(rgt);
        tup[0] = round_half_up(rgt[1] * fwd[2] - rgt[2] * fwd[1]);
        tup[1] = round_half_up(rgt[2] * fwd[0] - rgt[0] * fwd[2]);
        tup[2] = round_half_up(rgt[0] * fwd[1] - rgt[1] * fwd[0]);
        degen = !(ok_f && ok_r);
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) ent[i] = rgt[i];
                else if (k == 1) ent[i] = tup[i];
                else ent[i] = -fwd[i];
            end
            dot = ent[0] * eye[0] + ent[1] * eye[1] + ent[2] * eye[2];
            r.row = k[1:0];
            r.c0 = 32'(clamp32(ent[0]));
            r.c1 = 32'(clamp32(ent[1]));
            r.c2 = 32'(clamp32(ent[2]));
            r.c3 = 32'(clamp32(round_half_up(-dot)));
            r.last = 1'b0;
            r.degen = degen;
            rows_due.push_back(r);
        end
        r.row = ROW_LAST;
        r.c0 = 0; r.c1 = 0; r.c2 = 0;
        r.c3 = 32'sd1 <<< FRAC_BITS;
        r.last = 1'b1;
        r.degen = degen;
        rows_due.push_back(r);
    endtask

    task automatic send_camera(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        longint e[3], t[3], u[3];
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_eye_x <= ex; i_eye_y <= ey; i_eye_z <= ez;
        i_target_x <= tx; i_target_y <= ty; i_target_z <= tz;
        i_up_x <= ux; i_up_y <= uy; i_up_z <= uz;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        e = '{longint'($signed(ex)), longint'($signed(ey)), longint'($signed(ez))};
        t = '{longint'($signed(tx)), longint'($signed(ty)), longint'($signed(tz))};
        u = '{longint'($signed(ux)), longint'($signed(uy)), longint'($signed(uz))};
        predict_view_rows(e, t, u);
        @(negedge i_clk);
    endtask

    task automatic drain_rows();
        i_valid <= 1'b0;
        wait (rows_due.size() == 0);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // small coordinates keep the translation in range most of the time
    function automatic logic [31:0] coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            2: return 32'($signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000);
            default: return 32'($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] one, mx, mn;
        one = 32'h0001_0000; mx = 32'h7FFF_FFFF; mn = 32'h8000_0000;
        send_camera(0, 0, 5 * one, 0, 0, 0, 0, one, 0);
        send_camera(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0);
        send_camera(0, 0, 0, 0, one, 0, 0, one, 0);
        send_camera(0, 0, 0, 0, -one, 0, 0, 3 * one, 0);
        send_camera(0, 0, 0, one, 0, 0, 0, 0, 0);
        send_camera(mx, mx, mx, mn, mn, mn, 0, one, 0);
        send_camera(mn, mn, mn, mx, mx, mx, mx, mn, mx);
        send_camera(mx, mn, mx, mn, mx, mn, mn, mn, mn);
        send_camera(mn, 0, mx, 0, 0, 0, 1, 0, 0);
        send_camera(mx, mx, mx, mx - 1, mx, mx, 0, 0, 1);
        send_camera(-one, -one, -one, one, one, one, -one, one, -one);
        send_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0,
                    32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        send_camera(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1);
        drain_rows();
    endtask

    task automatic test_random(int n);
        logic [31:0] e[3], t[3], u[3];
        for (int k = 0; k < n; k++) begin
            foreach (e[i]) e[i] = coord();
            foreach (t[i]) t[i] = coord();
            foreach (u[i]) u[i] = coord();
            if ($urandom_range(0, 15) == 0) t = e;
            if ($urandom_range(0, 15) == 0)
                foreach (u[i]) u[i] = t[i] - e[i];
            send_camera(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
        end
    endtask

    // more items than the pipeline holds, so the input stalls during the hold
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        sender_gaps = 1'b0;
        test_random(150);
        sender_gaps = 1'b1;
        hold_receiver = 1'b0;
        drain_rows();
    endtask

    task automatic test_full_rate();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        test_random(50);
        drain_rows();
    endtask

    always @(negedge i_clk) begin
        if (hold_receiver) begin
            i_stall <= 1'b1;
            repeat (400) @(negedge i_clk);
            i_stall <= 1'b0;
            wait (!hold_receiver);
        end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_row want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rows_due.size() == 0) begin
                errors++;
                $display("%0t unexpected row item: row %0d cols %h %h %h %h", $time,
                         o_row_index, o_col0, o_col1, o_col2, o_col3);
            end else begin
                want = rows_due.pop_front();
                if (want.row !== o_row_index || want.c0 !== o_col0 ||
                    want.c1 !== o_col1 || want.c2 !== o_col2 || want.c3 !== o_col3 ||
                    want.last !== o_last_row || want.degen !== o_degenerate) begin
                    errors++;
                    $display("%0t row mismatch: expected row %0d %h %h %h %h last %b deg %b",
                             $time, want.row, want.c0, want.c1, want.c2, want.c3,
                             want.last, want.degen);
                    $display("%0t                 actual row %0d %h %h %h %h last %b deg %b",
                             $time, o_row_index, o_col0, o_col1, o_col2, o_col3,
                             o_last_row, o_degenerate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(100);
        drain_rows();
        test_backpressure();
        test_full_rate();
        if (errors == 0 && rows_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
